// File: hdl/pale_pkg.sv
// Shared types, widths and codes for the positional array list engine.
`default_nettype none
package pale_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OP_W      = 2;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_SCAN
  } state_t;

  // per-cell shift and load command
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: hdl/pale_if.sv
// Handshake channels for list operation items and result items.
`default_nettype none
interface pale_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [pale_pkg::OP_W-1:0]        operation;
  logic        [pale_pkg::POS_W-1:0]       position;
  logic signed [pale_pkg::VAL_W-1:0]       value;

  modport source(output valid, operation, position, value, input ready);
  modport sink(input valid, operation, position, value, output ready);
endinterface

interface pale_out_if;
  logic                                    valid;
  logic                                    ready;
  logic        [pale_pkg::STAT_W-1:0]      status;
  logic        [pale_pkg::POS_W-1:0]       found_position;
  logic signed [pale_pkg::VAL_W-1:0]       entry_value;
  logic        [pale_pkg::CNT_OUT_W-1:0]   entry_count;
  logic                                    last;

  modport source(output valid, status, found_position, entry_value, entry_count, last,
                 input ready);
  modport sink(input valid, status, found_position, entry_value, entry_count, last,
               output ready);
endinterface
`default_nettype wire

// File: hdl/pale_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares with the search key.
`default_nettype none
module pale_cell (
  input  wire logic                              clk,
  input  wire pale_pkg::cell_ctl_t               ctl,
  input  wire logic signed [pale_pkg::VAL_W-1:0] value,
  input  wire logic signed [pale_pkg::VAL_W-1:0] left,
  input  wire logic signed [pale_pkg::VAL_W-1:0] right,
  input  wire logic signed [pale_pkg::VAL_W-1:0] key,
  output logic signed [pale_pkg::VAL_W-1:0]      data,
  output logic                                   match
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= value;
    end else if (ctl.take_left) begin
      data <= left;
    end else if (ctl.take_right) begin
      data <= right;
    end
  end

  assign match = (data == key);

endmodule
`default_nettype wire

// File: hdl/positional_array_list_engine_top.sv
// Top level: chain of list cells plus the operation sequencer and result register.
// Insert, delete and update: one item at a time, result loaded into the output register as the item is accepted.
// Search: the S_SRCH state captures the match vector from all cells, then a scan counter walks
//   the positions one per cycle, holding on a match until the output slot is free; new items
//   are refused (ready low) until the last search result has been loaded.
// A new item is taken only once the previous one has produced its last result.
// Synchronous reset clears the count, the sequencer and the output valid; entries are not
//   cleared and are only read below the count.
`default_nettype none
module positional_array_list_engine_top #(
  parameter int DEPTH = pale_pkg::DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pale_in_if.sink     in_ch,
  pale_out_if.source  out_ch
);

  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CW > pale_pkg::POS_W) ? CW : pale_pkg::POS_W) + 1;
  localparam int VW    = pale_pkg::VAL_W;

  pale_pkg::state_t                state, state_next;
  logic [CW-1:0]                   count, count_next;
  logic [IW-1:0]                   idx, idx_next;
  logic [DEPTH-1:0]                mvec, mvec_next;
  logic signed [VW-1:0]            key;

  logic                            out_valid;
  pale_pkg::status_t               out_status;
  logic [pale_pkg::POS_W-1:0]      out_pos;
  logic signed [VW-1:0]            out_val;
  logic [pale_pkg::CNT_OUT_W-1:0]  out_cnt;
  logic                            out_last;

  logic                            load_out;
  pale_pkg::status_t               ld_status;
  logic [pale_pkg::POS_W-1:0]      ld_pos;
  logic signed [VW-1:0]            ld_val;
  logic                            ld_last;

  pale_pkg::cell_ctl_t             cell_ctl [DEPTH];
  logic signed [VW-1:0]            cell_data [DEPTH];
  logic [DEPTH-1:0]                cell_match;

  pale_pkg::op_t                   op;
  logic                            accept;
  logic                            slot_free;
  logic [CMP_W-1:0]                pos_e, cnt_e;
  logic [IW-1:0]                   k;
  logic                            ins_ok, del_ok, upd_ok, pos_bad_ins, pos_bad_mod, is_full;
  logic [DEPTH-1:0]                mvec_clr;

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VW-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = cell_data[g];
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    pale_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[g]),
      .value (in_ch.value),
      .left  (left_d),
      .right (right_d),
      .key   (key),
      .data  (cell_data[g]),
      .match (cell_match[g])
    );
  end

  assign op          = pale_pkg::op_t'(in_ch.operation);
  assign slot_free   = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == pale_pkg::S_IDLE) && slot_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_e       = CMP_W'(in_ch.position);
  assign cnt_e       = CMP_W'(count);
  assign k           = IW'(pos_e - CMP_W'(1));
  assign is_full     = (count == CW'(DEPTH));
  assign pos_bad_ins = (pos_e == '0) || (pos_e > cnt_e + CMP_W'(1));
  assign pos_bad_mod = (pos_e == '0) || (pos_e > cnt_e);
  assign ins_ok      = accept && (op == pale_pkg::OP_INSERT) && !pos_bad_ins && !is_full;
  assign del_ok      = accept && (op == pale_pkg::OP_DELETE) && !pos_bad_mod;
  assign upd_ok      = accept && (op == pale_pkg::OP_UPDATE) && !pos_bad_mod;
  assign mvec_clr    = mvec & ~(DEPTH'(1) << idx);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].load       = (ins_ok || upd_ok) && (IW'(i) == k);
      cell_ctl[i].take_left  = ins_ok && (IW'(i) > k);
      cell_ctl[i].take_right = del_ok && (IW'(i) >= k);
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    mvec_next  = mvec;
    load_out   = 1'b0;
    ld_status  = pale_pkg::ST_OK;
    ld_pos     = in_ch.position;
    ld_val     = '0;
    ld_last    = 1'b1;
    case (state)
      pale_pkg::S_IDLE: begin
        if (accept) begin
          case (op)
            pale_pkg::OP_INSERT: begin
              load_out = 1'b1;
              if (pos_bad_ins) begin
                ld_status = pale_pkg::ST_RANGE;
              end else if (is_full) begin
                ld_status = pale_pkg::ST_FULL;
              end else begin
                ld_val     = in_ch.value;
                count_next = count + CW'(1);
              end
            end
            pale_pkg::OP_DELETE: begin
              load_out = 1'b1;
              if (pos_bad_mod) begin
                ld_status = pale_pkg::ST_RANGE;
              end else begin
                ld_val     = cell_data[k];
                count_next = count - CW'(1);
              end
            end
            pale_pkg::OP_UPDATE: begin
              load_out = 1'b1;
              if (pos_bad_mod) begin
                ld_status = pale_pkg::ST_RANGE;
              end else begin
                ld_val = in_ch.value;
              end
            end
            default: begin
              state_next = pale_pkg::S_SRCH;
            end
          endcase
        end
      end
      pale_pkg::S_SRCH: begin
        // cells compare against the latched key; keep only held positions
        for (int i = 0; i < DEPTH; i++) begin
          mvec_next[i] = cell_match[i] && (CW'(i) < count);
        end
        idx_next   = '0;
        state_next = pale_pkg::S_SCAN;
      end
      pale_pkg::S_SCAN: begin
        if (mvec == '0) begin
          // nothing matched at all
          if (slot_free) begin
            load_out   = 1'b1;
            ld_status  = pale_pkg::ST_NOTFOUND;
            ld_pos     = '0;
            state_next = pale_pkg::S_IDLE;
          end
        end else if (mvec[idx]) begin
          if (slot_free) begin
            load_out  = 1'b1;
            ld_pos    = pale_pkg::POS_W'(CW'(idx) + CW'(1));
            ld_val    = key;
            ld_last   = (mvec_clr == '0);
            mvec_next = mvec_clr;
            idx_next  = idx + IW'(1);
            if (mvec_clr == '0) begin
              state_next = pale_pkg::S_IDLE;
            end
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      default: begin
        state_next = pale_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pale_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    mvec <= mvec_next;
    if (accept && (op == pale_pkg::OP_SEARCH)) begin
      key <= in_ch.value;
    end
    if (load_out) begin
      out_status <= ld_status;
      out_pos    <= ld_pos;
      out_val    <= ld_val;
      out_cnt    <= pale_pkg::CNT_OUT_W'(count_next);
      out_last   <= ld_last;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.found_position = out_pos;
  assign out_ch.entry_value    = out_val;
  assign out_ch.entry_count    = out_cnt;
  assign out_ch.last           = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> (count == $past(count) + CW'(1)))
    else $error("insert did not bump the count");

  a_scan_shrink: assert property (@(posedge clk) disable iff (rst)
    (state == pale_pkg::S_SCAN) |=> ((mvec & ~$past(mvec)) == '0))
    else $error("match vector gained bits during scan");

  a_busy_ready: assert property (@(posedge clk) disable iff (rst)
    (state != pale_pkg::S_IDLE) |-> !in_ch.ready)
    else $error("new item taken while a search is running");

endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the positional array list engine: directed and random list ops.
`timescale 1ns / 1ps
module tb;

  localparam int IDLE_PCT       = 34;
  localparam int RANDOM_ITEMS   = 445;
  localparam int RX_HOLD_CYCLES = 240;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct {
    pale_pkg::status_t                     status;
    logic [pale_pkg::POS_W-1:0]            found_position;
    logic signed [pale_pkg::VAL_W-1:0]     entry_value;
    logic [pale_pkg::CNT_OUT_W-1:0]        entry_count;
    logic                                  last;
  } list_result_t;

  // Shadow copy of the list plus the queue of results it predicts.
  class list_scoreboard;
    logic signed [pale_pkg::VAL_W-1:0] shadow_entries [pale_pkg::DEPTH_DEF];
    int                                shadow_count;
    list_result_t                      pending_list_results[$];
    int                                errors;
    int                                results_checked;
    int                                full_rejects;
    int                                range_rejects;
    int                                multi_match_searches;

    function new();
      shadow_count         = 0;
      errors               = 0;
      results_checked      = 0;
      full_rejects         = 0;
      range_rejects        = 0;
      multi_match_searches = 0;
    endfunction

    function void push_result(pale_pkg::status_t st, int p,
                              logic signed [pale_pkg::VAL_W-1:0] v, logic lst);
      list_result_t r;
      r.status         = st;
      r.found_position = pale_pkg::POS_W'(p);
      r.entry_value    = v;
      r.entry_count    = pale_pkg::CNT_OUT_W'(shadow_count);
      r.last           = lst;
      pending_list_results.push_back(r);
    endfunction

    function void predict_list_op(pale_pkg::op_t op, logic [pale_pkg::POS_W-1:0] pos,
                                  logic signed [pale_pkg::VAL_W-1:0] v);
      int p;
      int hits;
      logic signed [pale_pkg::VAL_W-1:0] removed;
      p = int'(pos);
      case (op)
        pale_pkg::OP_INSERT: begin
          if (p == 0 || p > shadow_count + 1) begin
            range_rejects++;
            push_result(pale_pkg::ST_RANGE, p, '0, 1'b1);
          end else if (shadow_count >= pale_pkg::DEPTH_DEF) begin
            full_rejects++;
            push_result(pale_pkg::ST_FULL, p, '0, 1'b1);
          end else begin
            for (int i = shadow_count; i >= p; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[p-1] = v;
            shadow_count++;
            push_result(pale_pkg::ST_OK, p, v, 1'b1);
          end
        end
        pale_pkg::OP_DELETE: begin
          if (p == 0 || p > shadow_count) begin
            range_rejects++;
            push_result(pale_pkg::ST_RANGE, p, '0, 1'b1);
          end else begin
            removed = shadow_entries[p-1];
            for (int i = p; i < shadow_count; i++) shadow_entries[i-1] = shadow_entries[i];
            shadow_count--;
            push_result(pale_pkg::ST_OK, p, removed, 1'b1);
          end
        end
        pale_pkg::OP_UPDATE: begin
          if (p == 0 || p > shadow_count) begin
            range_rejects++;
            push_result(pale_pkg::ST_RANGE, p, '0, 1'b1);
          end else begin
            shadow_entries[p-1] = v;
            push_result(pale_pkg::ST_OK, p, v, 1'b1);
          end
        end
        default: begin
          hits = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_entries[i] == v) begin
              push_result(pale_pkg::ST_OK, i + 1, v, 1'b0);
              hits++;
            end
          end
          if (hits == 0) push_result(pale_pkg::ST_NOTFOUND, 0, '0, 1'b1);
          else pending_list_results[pending_list_results.size()-1].last = 1'b1;
          if (hits > 1) multi_match_searches++;
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      results_checked++;
      if (pending_list_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result st=%0d pos=%0d val=%0d cnt=%0d last=%0d",
                                  got.status, got.found_position, got.entry_value,
                                  got.entry_count, got.last));
      end else begin
        want = pending_list_results.pop_front();
        if (got.status !== want.status || got.found_position !== want.found_position ||
            got.entry_value !== want.entry_value || got.entry_count !== want.entry_count ||
            got.last !== want.last)
          report_mismatch({
            $sformatf("got st=%0d pos=%0d val=%0d cnt=%0d last=%0d",
                      got.status, got.found_position, got.entry_value, got.entry_count,
                      got.last),
            $sformatf(", want st=%0d pos=%0d val=%0d cnt=%0d last=%0d",
                      want.status, want.found_position, want.entry_value, want.entry_count,
                      want.last)});
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   cycle_count = 0;
  bit   calm        = 1'b0;
  bit   rx_hold_req = 1'b0;
  int   items_sent  = 0;
  logic signed [pale_pkg::VAL_W-1:0] value_pool [4];

  list_scoreboard sb = new();

  pale_in_if  op_ch();
  pale_out_if res_ch();

  positional_array_list_engine_top dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (op_ch),
    .out_ch(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** positional_array_list_engine_top: FAILED **");
    $finish;
  end

  // Called right after the clock rises; returns right after the clock rise at which the item was taken.
  task automatic send_item(pale_pkg::op_t op, int pos, logic signed [pale_pkg::VAL_W-1:0] v);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid     <= 1'b1;
    op_ch.operation <= op;
    op_ch.position  <= pos[pale_pkg::POS_W-1:0];
    op_ch.value     <= v;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    sb.predict_list_op(op, pos[pale_pkg::POS_W-1:0], v);
    items_sent++;
  endtask

  function automatic logic signed [pale_pkg::VAL_W-1:0] pick_value();
    if ($urandom_range(99) < 85) return value_pool[$urandom_range(3)];
    return $urandom();
  endfunction

  task automatic wait_drained();
    while (sb.pending_list_results.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int hold_left;
    list_result_t got;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.status         = pale_pkg::status_t'(res_ch.status);
        got.found_position = res_ch.found_position;
        got.entry_value    = res_ch.entry_value;
        got.entry_count    = res_ch.entry_count;
        got.last           = res_ch.last;
        sb.check_result(got);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int mode;
    int r;
    int pos;
    pale_pkg::op_t op;
    rst              <= 1'b1;
    op_ch.valid      <= 1'b0;
    op_ch.operation  <= pale_pkg::OP_INSERT;
    op_ch.position   <= '0;
    op_ch.value      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty list: every position is out of range, search misses
    send_item(pale_pkg::OP_SEARCH, 0, 32'sd5);
    send_item(pale_pkg::OP_DELETE, 1, 32'sd0);
    send_item(pale_pkg::OP_UPDATE, 1, 32'sd3);
    send_item(pale_pkg::OP_INSERT, 0, 32'sd1);
    send_item(pale_pkg::OP_INSERT, 2, 32'sd1);
    // fill to capacity with inserts at front, back and middle
    for (int i = 0; i < pale_pkg::DEPTH_DEF; i++) begin
      case (i % 3)
        0:       pos = 1;
        1:       pos = sb.shadow_count + 1;
        default: pos = sb.shadow_count / 2 + 1;
      endcase
      if (i == 0) send_item(pale_pkg::OP_INSERT, pos, 32'sh8000_0000);
      else if (i == 1) send_item(pale_pkg::OP_INSERT, pos, 32'sh7fff_ffff);
      else send_item(pale_pkg::OP_INSERT, pos, (i % 2) ? 32'sd7 : -32'sd1);
    end
    send_item(pale_pkg::OP_INSERT, 5, 32'sd9);                    // full list
    send_item(pale_pkg::OP_SEARCH, 0, 32'sd7);                    // several hits
    send_item(pale_pkg::OP_UPDATE, pale_pkg::DEPTH_DEF, 32'sd7);
    send_item(pale_pkg::OP_DELETE, pale_pkg::DEPTH_DEF, 32'sd0);  // last entry
    send_item(pale_pkg::OP_DELETE, 1, 32'sd0);                    // first entry
    send_item(pale_pkg::OP_INSERT, 31, 32'sd2);                   // all position bits set

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 40 == 0) begin
        mode = $urandom_range(2);
        if ($urandom_range(3) == 0) begin
          value_pool[0] = $urandom_range(9);
          for (int j = 1; j < 4; j++) value_pool[j] = value_pool[0];
        end else begin
          for (int j = 0; j < 4; j++) begin
            r = $urandom_range(9);
            value_pool[j] = (r == 0) ? 32'sh8000_0000 :
                            (r == 1) ? 32'sh7fff_ffff : $signed(32'($urandom_range(9))) - 4;
          end
        end
      end
      if (k == 120) rx_hold_req = 1'b1;
      if (k == 200) calm = 1'b1;
      if (k == 270) calm = 1'b0;
      if (k == 330) begin
        op_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end

      r = $urandom_range(99);
      case (mode)
        0:       op = (r < 60) ? pale_pkg::OP_INSERT : (r < 70) ? pale_pkg::OP_DELETE :
                      (r < 85) ? pale_pkg::OP_SEARCH : pale_pkg::OP_UPDATE;
        1:       op = (r < 15) ? pale_pkg::OP_INSERT : (r < 70) ? pale_pkg::OP_DELETE :
                      (r < 85) ? pale_pkg::OP_SEARCH : pale_pkg::OP_UPDATE;
        default: op = (r < 30) ? pale_pkg::OP_INSERT : (r < 55) ? pale_pkg::OP_DELETE :
                      (r < 80) ? pale_pkg::OP_SEARCH : pale_pkg::OP_UPDATE;
      endcase
      if ($urandom_range(99) < 15) pos = $urandom_range(31);
      else if (op == pale_pkg::OP_INSERT) pos = $urandom_range(sb.shadow_count + 1, 1);
      else if (sb.shadow_count == 0) pos = 1;
      else pos = $urandom_range(sb.shadow_count, 1);
      send_item(op, pos, pick_value());
    end

    op_ch.valid <= 1'b0;
    wait_drained();
    repeat (pale_pkg::DEPTH_DEF + 4) @(posedge clk);
    $display("covered %0d list ops and %0d results: %0d full-list inserts refused,",
             items_sent, sb.results_checked, sb.full_rejects);
    $display("%0d out-of-range positions, %0d searches with several hits",
             sb.range_rejects, sb.multi_match_searches);
    if (sb.errors == 0) begin
      $display("** positional_array_list_engine_top: PASSED **");
    end else begin
      $display("** positional_array_list_engine_top: FAILED **");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/pale_pkg.sv
hdl/pale_if.sv
hdl/pale_cell.sv
hdl/positional_array_list_engine_top.sv
dv/tb.sv
